>>> rtl/mbps_pkg.sv
package mbps_pkg;

   localparam int MaxPatternBytes = 16;
   localparam int ByteWidth       = 8;
   localparam int CountWidth      = 32;
   localparam int AddrWidth       = 64;
   localparam int LenWidth        = 5;
   localparam int AgeWidth        = $clog2(MaxPatternBytes);
   localparam int CsrIndexWidth   = 3;
   localparam int CsrDataWidth    = 64;
   localparam int HalfBytes       = MaxPatternBytes / 2;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_CARE_MASK    = 3'd2,
      CSR_PATTERN_LEN  = 3'd3,
      CSR_REGION_BASE  = 3'd4
   } csr_index_type;

   typedef logic [ByteWidth-1:0] data_byte_type;
   typedef logic [MaxPatternBytes-1:0][ByteWidth-1:0] window_type;

   typedef struct packed {
      window_type                 pattern;
      logic [MaxPatternBytes-1:0] care_mask;
      logic [LenWidth-1:0]        length;
   } match_cfg_type;

endpackage

>>> rtl/mbps_window_match.sv
module mbps_window_match
   import mbps_pkg::*;
(
   input  window_type             window,
   input  logic [CountWidth-1:0]  bytes_seen,
   input  match_cfg_type          cfg,
   output logic                   hit
);

   logic [MaxPatternBytes-1:0] byte_ok;

   // pattern byte i lines up with the byte received len-1-i words ago
   always_comb begin
      logic [LenWidth-1:0] age;
      for (int i = 0; i < MaxPatternBytes; i++) begin
         age = cfg.length - LenWidth'(1) - LenWidth'(i);
         byte_ok[i] = (LenWidth'(i) >= cfg.length) || !cfg.care_mask[i] ||
                      (window[age[AgeWidth-1:0]] == cfg.pattern[i]);
      end
   end

   assign hit = (&byte_ok) && (bytes_seen >= CountWidth'(cfg.length));

endmodule

>>> rtl/masked_byte_pattern_search_unit.sv
// masked byte pattern search
// req channel: one region byte per word (req_data_byte) with req_last_byte
// marking the final byte of the region. a word is taken when req_valid is
// high and req_stall is low; one word can be taken every cycle.
// rsp channel: at most one word per region. rsp_found = 1 with
// rsp_match_address = region base + offset of the first match, or
// rsp_found = 0 and address 0 when the region ends with no match. bytes
// after a match are dropped; the last byte always restarts the search.
// the result word is registered: a taken byte passes the input register and
// then the result register. sustained rate is one byte per cycle while
// rsp_stall is low, set by the combinational parallel compare of the 16-byte window.
// csr port: write-only, csr_index picks the register, csr_write_data
// carries the value; write only while no byte is in flight.
// reset (synchronous, active high) clears the valid bits of both pipeline
// registers, the window, the byte count, and loads the register reset values.
// when rsp_stall is high the result word holds; one more byte may be
// taken into the input register, then req_stall rises.
module masked_byte_pattern_search_unit
   import mbps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ByteWidth-1:0]      req_data_byte,
   input  logic                      req_last_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic [AddrWidth-1:0]      rsp_match_address,
   input  logic                      csr_write_enable,
   input  logic [CsrIndexWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0]   csr_write_data
);

   logic [HalfBytes*ByteWidth-1:0] pat_low_ff, pat_low_in;
   logic [HalfBytes*ByteWidth-1:0] pat_high_ff, pat_high_in;
   logic [MaxPatternBytes-1:0]     care_mask_ff, care_mask_in;
   logic [LenWidth-1:0]            pat_len_ff, pat_len_in;
   logic [AddrWidth-1:0]           base_ff, base_in;

   logic                           s1_valid_ff, s1_valid_in;
   data_byte_type                  s1_data_ff, s1_data_in;
   logic                           s1_last_ff, s1_last_in;

   window_type                     window_ff, window_in;
   logic [CountWidth-1:0]          seen_ff, seen_in;
   logic                           done_ff, done_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_found_ff, rsp_found_in;
   logic [AddrWidth-1:0]           rsp_addr_ff, rsp_addr_in;

   logic                           out_free;
   logic                           advance;
   window_type                     window_shift;
   logic [CountWidth-1:0]          seen_inc;
   logic [CountWidth-1:0]          offset;
   logic [LenWidth-1:0]            eff_len;
   match_cfg_type                  cfg;
   logic                           hit_raw;
   logic                           hit;
   logic                           emit;

   // clamp length into 1..max
   always_comb begin
      if (pat_len_ff == '0) begin
         eff_len = LenWidth'(1);
      end else if (pat_len_ff > LenWidth'(MaxPatternBytes)) begin
         eff_len = LenWidth'(MaxPatternBytes);
      end else begin
         eff_len = pat_len_ff;
      end
   end

   assign cfg.pattern   = window_type'({pat_high_ff, pat_low_ff});
   assign cfg.care_mask = care_mask_ff;
   assign cfg.length    = eff_len;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   assign window_shift = {window_ff[MaxPatternBytes-2:0], s1_data_ff};
   assign seen_inc     = (seen_ff == {CountWidth{1'b1}}) ? seen_ff
                                                         : seen_ff + CountWidth'(1);
   assign offset       = seen_inc - CountWidth'(eff_len);

   mbps_window_match u_match (
      .window     (window_shift),
      .bytes_seen (seen_inc),
      .cfg        (cfg),
      .hit        (hit_raw)
   );

   assign hit  = !done_ff && hit_raw;
   assign emit = !done_ff && (hit_raw || s1_last_ff);

   // csr writes
   always_comb begin
      pat_low_in   = pat_low_ff;
      pat_high_in  = pat_high_ff;
      care_mask_in = care_mask_ff;
      pat_len_in   = pat_len_ff;
      base_in      = base_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pat_low_in   = csr_write_data[HalfBytes*ByteWidth-1:0];
            CSR_PATTERN_HIGH: pat_high_in  = csr_write_data[HalfBytes*ByteWidth-1:0];
            CSR_CARE_MASK:    care_mask_in = csr_write_data[MaxPatternBytes-1:0];
            CSR_PATTERN_LEN:  pat_len_in   = csr_write_data[LenWidth-1:0];
            CSR_REGION_BASE:  base_in      = csr_write_data[AddrWidth-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      s1_last_in  = s1_last_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data_byte;
         s1_last_in  = req_last_byte;
      end
   end

   // region state
   always_comb begin
      window_in = window_ff;
      seen_in   = seen_ff;
      done_in   = done_ff;
      if (advance) begin
         if (s1_last_ff) begin
            window_in = '0;
            seen_in   = '0;
            done_in   = 1'b0;
         end else if (!done_ff) begin
            window_in = window_shift;
            seen_in   = seen_inc;
            done_in   = hit_raw;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (advance) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_found_in = hit;
            rsp_addr_in  = hit ? base_ff + AddrWidth'(offset) : '0;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff   <= '0;
         pat_high_ff  <= '0;
         care_mask_ff <= '1;
         pat_len_ff   <= LenWidth'(1);
         base_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         window_ff    <= '0;
         seen_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_low_ff   <= pat_low_in;
         pat_high_ff  <= pat_high_in;
         care_mask_ff <= care_mask_in;
         pat_len_ff   <= pat_len_in;
         base_ff      <= base_in;
         s1_valid_ff  <= s1_valid_in;
         window_ff    <= window_in;
         seen_ff      <= seen_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff   <= s1_data_in;
      s1_last_ff   <= s1_last_in;
      rsp_found_ff <= rsp_found_in;
      rsp_addr_ff  <= rsp_addr_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_match_address = rsp_addr_ff;

endmodule

>>> verif/tb_masked_byte_pattern_search_unit.sv
`timescale 1ns / 100ps

module tb_masked_byte_pattern_search_unit;
   import mbps_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int IdlePercent = 34;

   typedef struct packed {
      logic                 found;
      logic [AddrWidth-1:0] address;
   } scan_outcome_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [ByteWidth-1:0]     req_data_byte = '0;
   logic                     req_last_byte = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_found;
   logic [AddrWidth-1:0]     rsp_match_address;
   logic                     csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_write_data = '0;

   // predictor copy of the registers and the search state
   window_type               pattern_bytes;
   logic [MaxPatternBytes-1:0] care_bits;
   logic [LenWidth-1:0]      length_reg;
   logic [AddrWidth-1:0]     region_base_reg;
   data_byte_type            recent_bytes [MaxPatternBytes];
   logic [CountWidth-1:0]    seen_count;
   logic                     region_hit;

   scan_outcome_type         expected_outcomes [$];
   int                       error_count = 0;
   int                       cycle_count = 0;
   int                       live_items = 0;
   bit                       calm = 1'b0;
   bit                       narrow_alphabet = 1'b0;

   masked_byte_pattern_search_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #4;
      clock = 1'b1;
      #4;
      clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("[masked_byte_pattern_search_unit] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IdlePercent);
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      scan_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch($sformatf("unexpected result word found=%b addr=%h",
                                      rsp_found, rsp_match_address));
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_found !== want.found)
               report_mismatch($sformatf("found %b, wanted %b", rsp_found, want.found));
            if (rsp_match_address !== want.address)
               report_mismatch($sformatf("match_address %h, wanted %h",
                                         rsp_match_address, want.address));
         end
      end
   end

   function automatic int unsigned active_length();
      if (length_reg == 0)
         return 1;
      if (length_reg > MaxPatternBytes)
         return MaxPatternBytes;
      return 32'(length_reg);
   endfunction

   task automatic restart_search();
      int k;
      for (k = 0; k < MaxPatternBytes; k++)
         recent_bytes[k] = '0;
      seen_count = '0;
      region_hit = 1'b0;
   endtask

   task automatic scan_byte(input data_byte_type b, input logic last);
      int unsigned n;
      int k;
      logic hit;
      live_items++;
      if (!region_hit) begin
         n = active_length();
         for (k = MaxPatternBytes - 1; k > 0; k--)
            recent_bytes[k] = recent_bytes[k-1];
         recent_bytes[0] = b;
         if (seen_count != '1)
            seen_count++;
         hit = (seen_count >= n);
         for (k = 0; k < n; k++)
            if (care_bits[k] && recent_bytes[n-1-k] != pattern_bytes[k])
               hit = 1'b0;
         if (hit) begin
            region_hit = 1'b1;
            expected_outcomes.push_back({1'b1,
               region_base_reg + AddrWidth'(seen_count - CountWidth'(n))});
         end else if (last) begin
            expected_outcomes.push_back({1'b0, {AddrWidth{1'b0}}});
         end
      end
      if (last)
         restart_search();
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] sel,
                            input logic [CsrDataWidth-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= sel;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (sel)
         CSR_PATTERN_LOW:  pattern_bytes[HalfBytes-1:0] = value;
         CSR_PATTERN_HIGH: pattern_bytes[MaxPatternBytes-1:HalfBytes] = value;
         CSR_CARE_MASK:    care_bits = value[MaxPatternBytes-1:0];
         CSR_PATTERN_LEN:  length_reg = value[LenWidth-1:0];
         CSR_REGION_BASE:  region_base_reg = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_byte(input data_byte_type b, input logic last);
      if (!calm && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      scan_byte(b, last);
   endtask

   task automatic send_region(input data_byte_type region_bytes[$]);
      int i;
      for (i = 0; i < region_bytes.size(); i++)
         send_byte(region_bytes[i], i == region_bytes.size() - 1);
   endtask

   // block idle: every result in, pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic make_region(output data_byte_type region_bytes[$]);
      int unsigned size, n, at, i, flip;
      region_bytes = {};
      n = active_length();
      size = ($urandom_range(99) < 85) ? $urandom_range(1, 20) : $urandom_range(21, 48);
      for (i = 0; i < size; i++)
         region_bytes.push_back(narrow_alphabet ? pattern_bytes[$urandom_range(n - 1)]
                                                : data_byte_type'($urandom_range(255)));
      if (size >= n && $urandom_range(99) < 65) begin
         at = $urandom_range(size - n);
         for (i = 0; i < n; i++)
            if (care_bits[i])
               region_bytes[at+i] = pattern_bytes[i];
         if ($urandom_range(99) < 20) begin
            flip = $urandom_range(n - 1);
            region_bytes[at+flip] = region_bytes[at+flip] ^ (8'h01 << $urandom_range(7));
         end
      end
   endtask

   task automatic random_settings(input int style);
      logic [CsrDataWidth-1:0] len_word;
      int j;
      len_word = {$urandom, $urandom};
      case (style)
         0: begin
            write_csr(CSR_PATTERN_LOW, '0);
            write_csr(CSR_PATTERN_HIGH, '1);
            write_csr(CSR_CARE_MASK, '1);
            write_csr(CSR_PATTERN_LEN, '1);
            write_csr(CSR_REGION_BASE, '1);
         end
         1: begin
            write_csr(CSR_PATTERN_LOW, '1);
            write_csr(CSR_PATTERN_HIGH, '0);
            write_csr(CSR_CARE_MASK, '0);
            write_csr(CSR_PATTERN_LEN, '0);
            write_csr(CSR_REGION_BASE, '0);
         end
         default: begin
            write_csr(CSR_PATTERN_LOW, {$urandom, $urandom});
            write_csr(CSR_PATTERN_HIGH, {$urandom, $urandom});
            case ($urandom_range(3))
               0: write_csr(CSR_CARE_MASK, '1);
               1: write_csr(CSR_CARE_MASK, {$urandom, $urandom} & ~64'hFFFF);
               default: write_csr(CSR_CARE_MASK, {$urandom, $urandom});
            endcase
            len_word[LenWidth-1:0] = ($urandom_range(99) < 70)
                                     ? LenWidth'($urandom_range(1, 6))
                                     : LenWidth'($urandom_range(0, 31));
            write_csr(CSR_PATTERN_LEN, len_word);
            case ($urandom_range(3))
               0: write_csr(CSR_REGION_BASE, '1 - $urandom_range(20));
               1: write_csr(CSR_REGION_BASE, '0);
               default: write_csr(CSR_REGION_BASE, {$urandom, $urandom});
            endcase
         end
      endcase
      if ($urandom_range(3) == 0)
         for (j = int'(CSR_REGION_BASE) + 1; j < (1 << CsrIndexWidth); j++)
            write_csr(j[CsrIndexWidth-1:0], {$urandom, $urandom});
   endtask

   task automatic test_reset_values();
      send_region('{8'h5A, 8'h00});
      send_region('{8'hFF});
      settle();
   endtask

   task automatic test_zero_length();
      write_csr(CSR_CARE_MASK, '0);
      write_csr(CSR_PATTERN_LEN, '0);
      write_csr(CSR_REGION_BASE, '1);
      send_region('{8'hA5, 8'h3C, 8'h81});
      settle();
   endtask

   // full 16-byte window with wildcard ends, match on the region's last word
   task automatic test_full_window();
      data_byte_type region_bytes[$];
      int i;
      write_csr(CSR_PATTERN_LOW, 64'h0123_4567_89AB_CDEF);
      write_csr(CSR_PATTERN_HIGH, 64'hFEDC_BA98_7654_3210);
      write_csr(CSR_CARE_MASK, 64'hFFFF_FFFF_FFFF_7FFE);
      write_csr(CSR_PATTERN_LEN, '1);
      region_bytes = {};
      for (i = 0; i < MaxPatternBytes; i++)
         region_bytes.push_back((i == 0 || i == MaxPatternBytes - 1) ? ~pattern_bytes[i]
                                                                     : pattern_bytes[i]);
      send_region(region_bytes);
      settle();
   endtask

   task automatic test_short_region();
      write_csr(CSR_CARE_MASK, '1);
      write_csr(CSR_PATTERN_LEN, 64'd3);
      write_csr(CSR_REGION_BASE, 64'h0000_1000);
      send_region('{pattern_bytes[0], pattern_bytes[1]});
      settle();
   endtask

   task automatic test_unused_index();
      int j;
      for (j = int'(CSR_REGION_BASE) + 1; j < (1 << CsrIndexWidth); j++)
         write_csr(j[CsrIndexWidth-1:0], '0);
      send_region('{pattern_bytes[0], pattern_bytes[1], pattern_bytes[2]});
      settle();
   endtask

   task automatic test_steady_stream();
      data_byte_type region_bytes[$];
      int start;
      random_settings(2);
      narrow_alphabet = 1'b1;
      calm = 1'b1;
      start = live_items;
      while (live_items - start < 120) begin
         make_region(region_bytes);
         send_region(region_bytes);
      end
      settle();
      calm = 1'b0;
   endtask

   task automatic test_random_regions();
      data_byte_type region_bytes[$];
      int start, phase_start, phase, i;
      start = live_items;
      phase = 0;
      while (live_items - start < 470) begin
         random_settings(phase);
         narrow_alphabet = ($urandom_range(99) < 35);
         phase_start = live_items;
         while (live_items - phase_start < 50) begin
            make_region(region_bytes);
            send_region(region_bytes);
         end
         // leave a region open across the register update
         if ($urandom_range(99) < 35)
            for (i = $urandom_range(1, 5); i > 0; i--)
               send_byte(data_byte_type'($urandom_range(255)), 1'b0);
         settle();
         phase++;
      end
   endtask

   task automatic test_noise();
      int start;
      random_settings(3);
      start = live_items;
      while (live_items - start < 60)
         send_byte(data_byte_type'($urandom_range(255)), $urandom_range(99) < 8);
      send_byte(data_byte_type'($urandom_range(255)), 1'b1);
      settle();
   endtask

   initial begin
      pattern_bytes = '0;
      care_bits = '1;
      length_reg = 5'd1;
      region_base_reg = '0;
      restart_search();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_zero_length();
      test_full_window();
      test_short_region();
      test_unused_index();
      test_steady_stream();
      test_random_regions();
      test_noise();
      settle();
      if (error_count == 0)
         $display("[masked_byte_pattern_search_unit] OK");
      else
         $display("[masked_byte_pattern_search_unit] ERROR");
      $finish;
   end

endmodule

>>> files.f
rtl/mbps_pkg.sv
rtl/mbps_window_match.sv
rtl/masked_byte_pattern_search_unit.sv
verif/tb_masked_byte_pattern_search_unit.sv
